// File: rtl/alis_pkg.sv
// Shared types, widths and codes for the array list block.
`timescale 1ns / 1ps
package alis_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [COUNT_W-1:0]   count;
  } res_t;

endpackage

// File: rtl/alis_if.sv
// Request and response channel interfaces of the array list block.
`timescale 1ns / 1ps
interface alis_in_if import alis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface alis_out_if import alis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, status, found, count, input ready);
  modport sink   (input valid, status, found, count, output ready);
endinterface

// File: rtl/alis_mem.sv
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module alis_mem #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int AW     = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/alis_ctrl.sv
// Request sequencer: append, shift-up insert and linear search over the entry memory.
`timescale 1ns / 1ps
module alis_ctrl import alis_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  alis_in_if.sink    in_ch,
  output logic       res_valid,
  output res_t       res,
  input  logic       res_ready
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SHIFT  = 7'b0000010,
    S_SHLAST = 7'b0000100,
    S_INSERT = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_SRLAST = 7'b0100000,
    S_REPLY  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      src_r, src_nxt;
  logic [IDX_W-1:0]      dst_r, dst_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  pend_r, pend_nxt;
  logic                  hit_r, hit_nxt;
  status_t               status_r, status_nxt;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [IDX_W-1:0]      raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic                  full;
  logic                  beyond;
  logic                  at_end;
  logic [DATA_WIDTH-1:0] in_val;

  alis_mem #(
    .DEPTH  (CAPACITY),
    .DATA_W (DATA_WIDTH),
    .AW     (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign beyond = (CMP_W'(in_ch.position) > CMP_W'(count_r));
  assign at_end = (CMP_W'(in_ch.position) == CMP_W'(count_r));
  assign in_val = DATA_WIDTH'(in_ch.value);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    pend_nxt   = pend_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = dst_r;
    wdata      = rdata;
    raddr      = src_r;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          val_nxt    = in_val;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          pend_nxt   = 1'b0;
          state_nxt  = S_REPLY;
          case (action_t'(in_ch.action))
            ACT_APPEND: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = IDX_W'(count_r);
                wdata     = in_val;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
            ACT_INSERT: begin
              if (beyond) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (at_end) begin
                we        = 1'b1;
                waddr     = IDX_W'(count_r);
                wdata     = in_val;
                count_nxt = CNT_W'(count_r + 1'b1);
              end else begin
                src_nxt   = IDX_W'(count_r - 1'b1);
                pos_nxt   = IDX_W'(in_ch.position);
                state_nxt = S_SHIFT;
              end
            end
            ACT_LOOKUP: begin
              if (count_r != '0) begin
                src_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Read one entry below while the previous read lands one slot up.
        we       = pend_r;
        pend_nxt = 1'b1;
        dst_nxt  = IDX_W'(src_r + 1'b1);
        if (src_r == pos_r) begin
          state_nxt = S_SHLAST;
        end else begin
          src_nxt = IDX_W'(src_r - 1'b1);
        end
      end

      S_SHLAST: begin
        we        = 1'b1;
        state_nxt = S_INSERT;
      end

      S_INSERT: begin
        we        = 1'b1;
        waddr     = pos_r;
        wdata     = val_r;
        count_nxt = CNT_W'(count_r + 1'b1);
        state_nxt = S_REPLY;
      end

      S_SEARCH: begin
        if (pend_r && (rdata == val_r)) begin
          hit_nxt = 1'b1;
        end
        pend_nxt = 1'b1;
        if (src_r == IDX_W'(count_r - 1'b1)) begin
          state_nxt = S_SRLAST;
        end else begin
          src_nxt = IDX_W'(src_r + 1'b1);
        end
      end

      S_SRLAST: begin
        if (rdata == val_r) begin
          hit_nxt = 1'b1;
        end
        state_nxt = S_REPLY;
      end

      S_REPLY: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status = status_r;
  assign res.found  = hit_r;
  assign res.count  = COUNT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
  end

endmodule

// File: rtl/array_list_insert_search_top.sv
// Top level of the fixed-capacity array list: sequencer, entry memory and response register.
// Appends, end inserts, errors, unused actions and empty lookups go straight to the reply;
// other lookups first scan every entry, and other inserts first shift the entries at and
// above the position up by one slot.
// Throughput: one request at a time; a new request is taken only once the previous result is handed over.
// Reset (synchronous, active low) empties the list; no memory clearing pass runs.
`timescale 1ns / 1ps
module array_list_insert_search_top import alis_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  alis_in_if.sink    in_ch,
  alis_out_if.source out_ch
);

  // Result handed over by the sequencer when it finishes a request.
  logic res_valid;
  logic res_ready;
  res_t res;

  // Response register. It parts the sequencer from the output side, so a
  // new request can be taken while the previous result still waits.
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  alis_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // The register takes a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_res_r.status;
  assign out_ch.found  = out_res_r.found;
  assign out_ch.count  = out_res_r.count;

`ifndef NO_ASSERTIONS
  // A request beat always starts work, so the sequencer is busy in the next cycle.
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted twice in a row");

  // A full status is only reported when the list really holds CAPACITY entries.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == ST_FULL) |-> (res.count == COUNT_W'(CAPACITY)))
    else $error("full status with a short list");

  // A failed request never reports a match.
  a_no_hit_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status != ST_OK) |-> !res.found)
    else $error("match reported on a failed request");

  // A result handed over fills the response register in the next cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_ch.valid)
    else $error("result lost on its way to the response register");
`endif

endmodule
